/* design/trpl_pkg.sv */
package trpl_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 64;
    localparam int unsigned BOUND_W         = 63;
    localparam int unsigned TAG_W           = 16;
    localparam int unsigned WIDTH_W         = 62;
    localparam int unsigned POS_W           = 10;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_Q_RD,
        S_Q_CHK,
        S_POS_WAIT
    } state_t;

    typedef struct packed {
        logic [BOUND_W-1:0] bound;
        logic [TAG_W-1:0]   tag;
    } entry_t;

endpackage

/* design/trpl_store.sv */
module trpl_store
    import trpl_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_ENTRIES_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/time_range_partition_lookup.sv */
// Sorted table of time partitions, each covering [bound - partition_width, bound),
// kept in one synchronous memory ordered by exclusive upper bound. Raise start
// with a mode while busy is low; the item is taken at that edge and exactly one
// result comes back on status/found_tag with done high for a single cycle. The
// receiver cannot stall: capture the result in the cycle done is high. Clear,
// insert into a full table and a read beyond the fill level finish straight from
// idle, with no memory access. Inserts and queries run a binary search first,
// each step one memory read, then the compare, up to ceil(log2(count+1)) steps,
// then the closed window hands the slot to the mode's tail. A query then reads
// and checks the found entry, if there is one. An insert then moves each entry
// above the slot up by one, a read and then a write, and ends with the new
// entry's write; the single memory port pair sets that cost. A read by position
// reads that one entry. Write partition_width only while idle; cfg_ready is
// always high.
module time_range_partition_lookup
    import trpl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [BOUND_W-1:0]  upper_bound,
    input  logic [TAG_W-1:0]    entry_tag,
    input  logic [BOUND_W-1:0]  timestamp,
    input  logic [POS_W-1:0]    position,
    output logic                done,
    output logic [1:0]          status,
    output logic [TAG_W-1:0]    found_tag,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WIDTH_W-1:0]  cfg_data
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned XW = POS_W + 1;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [BOUND_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [WIDTH_W-1:0] width_reg;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [TAG_W-1:0]   ftag_reg, ftag_next;

    logic          accept;
    logic [CW-1:0] mid;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;
    logic          lb_hit;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign found_tag = ftag_reg;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // ts >= bound - width, with the lower bound clamped at zero, is ts + width >= bound.
    assign lb_hit = (64'(key_reg) + 64'(width_reg)) >= 64'(rd_data.bound);

    trpl_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            width_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        tag_reg    <= tag_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        ftag_reg   <= ftag_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        tag_next    = tag_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        ftag_next   = ftag_reg;
        rd_en       = 1'b0;
        rd_addr     = mid[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = mode_t'(mode);
                    tag_next    = entry_tag;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    idx_next    = count_reg;
                    status_next = STAT_OK;
                    ftag_next   = '0;
                    key_next    = (mode_t'(mode) == MODE_INSERT) ? upper_bound : timestamp;
                    unique case (mode_t'(mode))
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                status_next = STAT_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        MODE_QUERY:
                        begin
                            state_next = S_SRCH_RD;
                        end
                        MODE_READ:
                        begin
                            if (XW'(position) < XW'(count_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = position[AW-1:0];
                                state_next = S_POS_WAIT;
                            end
                            else
                            begin
                                status_next = STAT_RANGE;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SRCH_RD:
            begin
                // issue the probe read, or hand the landing slot to the mode's tail
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[AW-1:0];
                    state_next = S_SRCH_CMP;
                end
                else if (mode_reg == MODE_INSERT)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end

            S_SRCH_CMP:
            begin
                if (rd_data.bound > key_reg)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + CW'(1);
                end
                state_next = S_SRCH_RD;
            end

            S_SHIFT_RD:
            begin
                // move entries above the slot up by one, top first
                if (idx_reg > lo_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg - CW'(1));
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = lo_reg[AW-1:0];
                    wr_data.bound = key_reg;
                    wr_data.tag   = tag_reg;
                    count_next    = count_reg + CW'(1);
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_reg - CW'(1);
                state_next = S_SHIFT_RD;
            end

            S_Q_RD:
            begin
                if (lo_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg[AW-1:0];
                    state_next = S_Q_CHK;
                end
                else
                begin
                    status_next = STAT_MISS;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_Q_CHK:
            begin
                if (lb_hit)
                begin
                    status_next = STAT_OK;
                    ftag_next   = rd_data.tag;
                end
                else
                begin
                    status_next = STAT_MISS;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_POS_WAIT:
            begin
                ftag_next  = rd_data.tag;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_SHIFT_WR) || (state_reg == S_SHIFT_RD)) &&
                  (mode_reg == MODE_INSERT))
        else $error("memory write outside an insert");

    a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            ($past(accept) && ($past(mode) == MODE_CLEAR)) ||
            ($past(state_reg) == S_SHIFT_RD && $past(wr_en)))
        else $error("entry count changed without clear or insert");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_CMP) |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("search window out of order");

    a_done_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while still working");
`endif

endmodule

/* tb/tb_time_range_partition_lookup.sv */
`timescale 1ns / 100ps

module tb_time_range_partition_lookup;
    import trpl_pkg::*;

    localparam int TBL_DEPTH    = MAX_ENTRIES_DEF;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int ITEM_TARGET  = 1150;
    localparam int IDLE_PCT     = 29;
    localparam int CALM_FIRST   = 500;   // items in this window go out with no random idle gaps
    localparam int CALM_LAST    = 700;
    localparam int SETTLE_CYCLES = 200;  // covers the longest insert, into a table one entry short of full
    localparam int LIMIT_CYCLES = 1_500_000;

    localparam logic [BOUND_W-1:0] BOUND_MAX = {BOUND_W{1'b1}};
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

    // What the stimulus queue holds: a command item, a partition width write,
    // or a marker that makes the sender wait until every result is back.
    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

    typedef struct {
        act_kind_t          kind;
        mode_t              op;
        logic [BOUND_W-1:0] ub;
        logic [TAG_W-1:0]   tag;
        logic [BOUND_W-1:0] ts;
        logic [POS_W-1:0]   pos;
        logic [WIDTH_W-1:0] width_val;
    } pending_t;

    typedef struct {
        status_t          status;
        logic [TAG_W-1:0] tag;
    } lookup_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = MODE_CLEAR;
    logic [BOUND_W-1:0] upper_bound = '0;
    logic [TAG_W-1:0]   entry_tag = '0;
    logic [BOUND_W-1:0] timestamp = '0;
    logic [POS_W-1:0]   position = '0;
    logic               done;
    logic [1:0]         status;
    logic [TAG_W-1:0]   found_tag;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [WIDTH_W-1:0] cfg_data = '0;

    pending_t       pending[$];
    lookup_result_t lookup_q[$];
    int             fail_count = 0;
    int             items_issued = 0;

    // Shadow copy of the partition table
    logic [BOUND_W-1:0] shadow_bound[TBL_DEPTH];
    logic [TAG_W-1:0]   shadow_tag[TBL_DEPTH];
    int                 shadow_count = 0;
    logic [WIDTH_W-1:0] shadow_width = '0;

    // Bounds queued for insert since the last clear, used to aim timestamps
    logic [BOUND_W-1:0] gen_bounds[$];
    int                 n_items = 0;

    pending_t cur_item;
    logic     took_item;
    logic     next_start;
    logic     next_cfg;

    time_range_partition_lookup #(
        .MAX_ENTRIES(TBL_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .upper_bound(upper_bound),
        .entry_tag  (entry_tag),
        .timestamp  (timestamp),
        .position   (position),
        .done       (done),
        .status     (status),
        .found_tag  (found_tag),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------

    // Return the first sorted slot whose bound is strictly above key.
    function automatic int first_bound_above(input logic [BOUND_W-1:0] key);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_bound[i] > key)
                return i;
        return shadow_count;
    endfunction

    // Apply one accepted item to the shadow table and queue its result.
    function automatic void predict_lookup(input pending_t it);
        lookup_result_t res;
        int             slot;
        logic [BOUND_W-1:0] hb;
        logic [BOUND_W-1:0] lb;
        res.status = STAT_OK;
        res.tag    = '0;
        case (it.op)
            MODE_CLEAR: shadow_count = 0;
            MODE_INSERT: begin
                if (shadow_count >= TBL_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // equal bounds land after the ones already stored
                    slot = first_bound_above(it.ub);
                    for (int i = shadow_count; i > slot; i--) begin
                        shadow_bound[i] = shadow_bound[i-1];
                        shadow_tag[i]   = shadow_tag[i-1];
                    end
                    shadow_bound[slot] = it.ub;
                    shadow_tag[slot]   = it.tag;
                    shadow_count++;
                end
            end
            MODE_QUERY: begin
                slot = first_bound_above(it.ts);
                res.status = STAT_MISS;
                if (slot < shadow_count) begin
                    hb = shadow_bound[slot];
                    // lower bound floors at zero when the width exceeds the bound
                    lb = ({1'b0, shadow_width} > hb) ? '0 : hb - {1'b0, shadow_width};
                    if (it.ts >= lb) begin
                        res.status = STAT_OK;
                        res.tag    = shadow_tag[slot];
                    end
                end
            end
            default: begin
                if (it.pos < shadow_count)
                    res.tag = shadow_tag[it.pos];
                else
                    res.status = STAT_RANGE;
            end
        endcase
        lookup_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present items and width writes from the pending queue
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            took_item = start && !busy;
            if (took_item) begin
                predict_lookup(cur_item);
                items_issued++;
            end
            if (cfg_valid && cfg_ready)
                shadow_width = cfg_data;

            // Hold an item or a write that has not been taken yet.
            if (!((start && !took_item) || (cfg_valid && !cfg_ready))) begin
                next_start = 1'b0;
                next_cfg   = 1'b0;
                if (pending.size() != 0) begin
                    case (pending[0].kind)
                        ACT_CFG: begin
                            // write the width only once the block has gone quiet
                            if (lookup_q.size() == 0 && !start && !busy) begin
                                cfg_data <= pending[0].width_val;
                                next_cfg = 1'b1;
                                void'(pending.pop_front());
                            end
                        end
                        ACT_DRAIN: begin
                            if (lookup_q.size() == 0 && !start)
                                void'(pending.pop_front());
                        end
                        default: begin
                            // idle now and then, except inside the calm window
                            if ((items_issued < CALM_FIRST || items_issued >= CALM_LAST)
                                && $urandom_range(99) < IDLE_PCT) begin
                                next_start = 1'b0;
                            end else begin
                                cur_item = pending.pop_front();
                                mode        <= cur_item.op;
                                upper_bound <= cur_item.ub;
                                entry_tag   <= cur_item.tag;
                                timestamp   <= cur_item.ts;
                                position    <= cur_item.pos;
                                next_start = 1'b1;
                            end
                        end
                    endcase
                end
                start     <= next_start;
                cfg_valid <= next_cfg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each strobed result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (lookup_q.size() == 0) begin
                $error("result with nothing expected: status %0d, found_tag %0h",
                       status, found_tag);
                fail_count++;
            end else begin
                if (status !== lookup_q[0].status) begin
                    $error("status: expected %0d, got %0d", lookup_q[0].status, status);
                    fail_count++;
                end
                if (found_tag !== lookup_q[0].tag) begin
                    $error("found_tag: expected %0h, got %0h", lookup_q[0].tag, found_tag);
                    fail_count++;
                end
                void'(lookup_q.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic [BOUND_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[BOUND_W-1:0];
    endfunction

    function automatic void push_item(input mode_t op, input logic [BOUND_W-1:0] ub,
                                      input logic [TAG_W-1:0] tag,
                                      input logic [BOUND_W-1:0] ts,
                                      input logic [POS_W-1:0] pos);
        pending_t it;
        it.kind = ACT_ITEM;
        it.op = op;
        it.ub = ub;
        it.tag = tag;
        it.ts = ts;
        it.pos = pos;
        it.width_val = '0;
        pending.push_back(it);
        n_items++;
        if (op == MODE_CLEAR)
            gen_bounds.delete();
        else if (op == MODE_INSERT)
            gen_bounds.push_back(ub);
    endfunction

    function automatic void push_width(input logic [WIDTH_W-1:0] w);
        pending_t it;
        it.kind = ACT_CFG;
        it.op = MODE_CLEAR;
        it.ub = '0;
        it.tag = '0;
        it.ts = '0;
        it.pos = '0;
        it.width_val = w;
        pending.push_back(it);
    endfunction

    function automatic void push_drain();
        pending_t it;
        it.kind = ACT_DRAIN;
        it.op = MODE_CLEAR;
        it.ub = '0;
        it.tag = '0;
        it.ts = '0;
        it.pos = '0;
        it.width_val = '0;
        pending.push_back(it);
    endfunction

    // Aim a timestamp near the base, at a queued bound, at a lower bound edge, or anywhere.
    function automatic logic [BOUND_W-1:0] pick_ts(input logic [WIDTH_W-1:0] w,
                                                  input logic [BOUND_W-1:0] base,
                                                  input int spread);
        logic [BOUND_W-1:0] hb;
        int                 sel;
        sel = $urandom_range(9);
        if (gen_bounds.size() == 0 || sel < 2)
            return rand63();
        if (sel < 4)
            return base + BOUND_W'($urandom_range(0, spread));
        hb = gen_bounds[$urandom_range(0, gen_bounds.size() - 1)];
        if (sel < 7)
            return hb - BOUND_W'(3) + BOUND_W'($urandom_range(0, 6));
        return hb - {1'b0, w} - BOUND_W'(2) + BOUND_W'($urandom_range(0, 4));
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(9) < 6)
            return POS_W'($urandom_range(0, TBL_DEPTH + 6));
        return POS_W'($urandom);
    endfunction

    function automatic void push_noise();
        push_item(mode_t'($urandom_range(3)), rand63(), TAG_W'($urandom), rand63(),
                  POS_W'($urandom));
    endfunction

    initial begin
        logic [WIDTH_W-1:0] w;
        logic [BOUND_W-1:0] base;
        logic [63:0]        r;
        int                 spread;
        int                 kind;
        int                 n_ops;
        int                 pick;

        // Directed: empty table, then a hand-built table probed at its edges.
        push_item(MODE_QUERY, '0, '0, '0, '0);
        push_item(MODE_READ, '0, '0, '0, '0);
        push_item(MODE_READ, '0, '0, '0, {POS_W{1'b1}});
        push_width(WIDTH_W'(100));
        push_item(MODE_INSERT, BOUND_W'(1000), 16'hAAAA, '0, '0);
        push_item(MODE_INSERT, BOUND_W'(1000), 16'h5555, '0, '0);  // lands after the first
        push_item(MODE_INSERT, '0, 16'hFFFF, '0, '0);
        push_item(MODE_INSERT, BOUND_MAX, 16'h0000, '0, '0);
        push_item(MODE_INSERT, BOUND_W'(50), 16'h0001, '0, '0);    // lower bound floors at 0
        push_item(MODE_QUERY, '0, '0, BOUND_W'(1000), '0);         // equal to a bound
        push_item(MODE_QUERY, '0, '0, BOUND_W'(999), '0);
        push_item(MODE_QUERY, '0, '0, BOUND_W'(900), '0);          // exactly the lower bound
        push_item(MODE_QUERY, '0, '0, BOUND_W'(899), '0);
        push_item(MODE_QUERY, '0, '0, '0, '0);
        push_item(MODE_QUERY, '0, '0, BOUND_MAX, '0);              // equal to the top bound
        push_item(MODE_QUERY, '0, '0, BOUND_MAX - 1, '0);
        push_item(MODE_READ, '0, '0, '0, POS_W'(0));
        push_item(MODE_READ, '0, '0, '0, POS_W'(2));
        push_item(MODE_READ, '0, '0, '0, POS_W'(3));
        push_item(MODE_READ, '0, '0, '0, POS_W'(4));
        push_item(MODE_READ, '0, '0, '0, POS_W'(5));               // one past the last entry
        push_width(WIDTH_MAX);
        push_item(MODE_QUERY, '0, '0, BOUND_W'(1000), '0);
        push_item(MODE_QUERY, '0, '0, {1'b1, {(BOUND_W-1){1'b0}}}, '0);
        push_item(MODE_QUERY, '0, '0, BOUND_W'(49), '0);
        push_item(MODE_CLEAR, '0, '0, '0, '0);
        push_item(MODE_QUERY, '0, '0, BOUND_W'(10), '0);
        push_item(MODE_READ, '0, '0, '0, '0);
        push_drain();

        // Random phases, each under its own partition width and time scale.
        while (n_items < ITEM_TARGET) begin
            r = {$urandom, $urandom};
            case ($urandom_range(4))
                0: w = '0;
                1: w = WIDTH_MAX;
                2: w = WIDTH_W'($urandom_range(1, 50));
                3: w = r[WIDTH_W-1:0];
                default: w = WIDTH_W'($urandom_range(100, 5000));
            endcase
            push_width(w);
            case ($urandom_range(2))
                0: base = BOUND_W'($urandom_range(0, 1000));
                1: base = BOUND_MAX - BOUND_W'($urandom_range(0, 100000));
                default: base = rand63();
            endcase
            spread = ($urandom_range(3) == 0) ? 20 : $urandom_range(1, 4000);
            kind = $urandom_range(9);

            if (kind < 2) begin
                // noise: every field random
                repeat (40) push_noise();
            end else if (kind < 4) begin
                // fill the table past its capacity, probing as it grows
                push_item(MODE_CLEAR, rand63(), TAG_W'($urandom), rand63(), POS_W'($urandom));
                for (int k = 0; k < TBL_DEPTH + $urandom_range(1, 4); k++) begin
                    push_item(MODE_INSERT, base + BOUND_W'($urandom_range(0, spread)),
                              TAG_W'($urandom), rand63(), POS_W'($urandom));
                    if (k % 4 == 3)
                        push_item(MODE_QUERY, rand63(), TAG_W'($urandom),
                                  pick_ts(w, base, spread), POS_W'($urandom));
                end
                repeat (8) push_item(MODE_READ, rand63(), TAG_W'($urandom), rand63(),
                                     pick_pos());
                repeat (8) push_item(MODE_QUERY, rand63(), TAG_W'($urandom),
                                     pick_ts(w, base, spread), POS_W'($urandom));
            end else begin
                if ($urandom_range(9) < 7)
                    push_item(MODE_CLEAR, rand63(), TAG_W'($urandom), rand63(),
                              POS_W'($urandom));
                n_ops = $urandom_range(40, 90);
                for (int k = 0; k < n_ops; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 40)
                        push_item(MODE_INSERT, base + BOUND_W'($urandom_range(0, spread)),
                                  TAG_W'($urandom), rand63(), POS_W'($urandom));
                    else if (pick < 75)
                        push_item(MODE_QUERY, rand63(), TAG_W'($urandom),
                                  pick_ts(w, base, spread), POS_W'($urandom));
                    else if (pick < 92)
                        push_item(MODE_READ, rand63(), TAG_W'($urandom), rand63(),
                                  pick_pos());
                    else if (pick < 95)
                        push_item(MODE_CLEAR, rand63(), TAG_W'($urandom), rand63(),
                                  POS_W'($urandom));
                    else
                        push_noise();
                end
            end
            // pause the sender until the table has answered everything
            if ($urandom_range(3) == 0)
                push_drain();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go out and every result to come back.
        while (pending.size() != 0 || start || lookup_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
design/trpl_pkg.sv
design/trpl_store.sv
design/time_range_partition_lookup.sv
tb/tb_time_range_partition_lookup.sv
